FILE: hw/rtl/btree_table_search_unit_defines.svh
// Assertion macros shared by the B-tree search unit RTL.
`ifndef BTREE_TABLE_SEARCH_UNIT_DEFINES_SVH
`define BTREE_TABLE_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bts_pkg.sv
// Shared types and constants of the B-tree search unit.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int NODE_W   = 7;
  localparam int SLOT_W   = 4;
  localparam int CNT_W    = 4;
  localparam int IN_KEY_W = 32;

  typedef enum logic [1:0] {
    OP_SET_COUNT   = 2'd0,
    OP_WRITE_KEY   = 2'd1,
    OP_WRITE_CHILD = 2'd2,
    OP_SEARCH      = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [NODE_W-1:0]   node_index;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    key_count;
    logic [IN_KEY_W-1:0] key_value;
    logic [NODE_W-1:0]   child_index;
    logic [IN_KEY_W-1:0] search_key;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] found_node;
    logic [SLOT_W-1:0] found_slot;
    logic              depth_exceeded;
  } res_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic clr;        // clear one count entry
    logic wr_item;    // table write transfer
    logic start;      // search transfer: load target and root
    logic node_rd;    // enter node: read count, form bases
    logic key_rd;     // read first key of node
    logic key_next;   // advance to next key
    logic child_rd;   // read child at current slot
    logic descend;    // move to child
    logic res_miss;
    logic res_dx;
    logic res_found;
    logic out_load;   // move pending result to output register
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic clr_done;
    logic in_search;
    logic node_ok;
    logic depth_hit;
    logic key_in_range;
    logic key_ge;
    logic key_eq;
  } status_t;

endpackage

FILE: hw/rtl/bts_in_if.sv
// Input item channel of the B-tree search unit.
`timescale 1ns / 1ps

interface bts_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [bts_pkg::NODE_W-1:0]    node_index;
  logic [bts_pkg::SLOT_W-1:0]    slot;
  logic [bts_pkg::CNT_W-1:0]     key_count;
  logic signed [bts_pkg::IN_KEY_W-1:0] key_value;
  logic [bts_pkg::NODE_W-1:0]    child_index;
  logic signed [bts_pkg::IN_KEY_W-1:0] search_key;

  modport source (
    output valid, op, node_index, slot, key_count, key_value, child_index, search_key,
    input  ready
  );
  modport sink (
    input  valid, op, node_index, slot, key_count, key_value, child_index, search_key,
    output ready
  );
endinterface

FILE: hw/rtl/bts_out_if.sv
// Result channel of the B-tree search unit.
`timescale 1ns / 1ps

interface bts_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [bts_pkg::NODE_W-1:0] found_node;
  logic [bts_pkg::SLOT_W-1:0] found_slot;
  logic                       depth_exceeded;

  modport source (
    output valid, found, found_node, found_slot, depth_exceeded,
    input  ready
  );
  modport sink (
    input  valid, found, found_node, found_slot, depth_exceeded,
    output ready
  );
endinterface

FILE: hw/rtl/bts_ctrl.sv
// Search sequencer and handshake control of the B-tree search unit.
`timescale 1ns / 1ps
`include "btree_table_search_unit_defines.svh"

module bts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bts_pkg::status_t status_i,
  output bts_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_NODE   = 3'd2;
  localparam logic [2:0] S_COUNT  = 3'd3;
  localparam logic [2:0] S_KEY    = 3'd4;
  localparam logic [2:0] S_CHILD  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.in_search) begin
            cmd_o.start = 1'b1;
            state_d     = S_NODE;
          end else begin
            cmd_o.wr_item = 1'b1;
          end
        end
      end
      S_NODE: begin
        if (!status_i.node_ok) begin
          cmd_o.res_miss = 1'b1;
          state_d        = S_FINISH;
        end else if (status_i.depth_hit) begin
          cmd_o.res_dx = 1'b1;
          state_d      = S_FINISH;
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d       = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.key_rd = 1'b1;
        state_d      = S_KEY;
      end
      S_KEY: begin
        if (status_i.key_in_range && !status_i.key_ge) begin
          cmd_o.key_next = 1'b1;
        end else if (status_i.key_in_range && status_i.key_eq) begin
          cmd_o.res_found = 1'b1;
          state_d         = S_FINISH;
        end else begin
          cmd_o.child_rd = 1'b1;
          state_d        = S_CHILD;
        end
      end
      S_CHILD: begin
        cmd_o.descend = 1'b1;
        state_d       = S_NODE;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `BTS_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0({cmd_o.clr, cmd_o.wr_item, cmd_o.start, cmd_o.node_rd, cmd_o.key_rd, cmd_o.key_next, cmd_o.child_rd, cmd_o.descend, cmd_o.res_miss, cmd_o.res_dx, cmd_o.res_found, cmd_o.out_load}), "more than one datapath command")
  `BTS_ASSERT_IMP(a_key_data, state_q == S_KEY, $past(cmd_o.key_rd || cmd_o.key_next), "key compare without a key read")
  `BTS_ASSERT_NEXT(a_finish_load, state_q == S_FINISH && slot_free, out_valid_q && state_q == S_IDLE, "finished result not presented")

endmodule

FILE: hw/rtl/bts_datapath.sv
// Node tables, walk registers and result registers of the B-tree search unit.
`timescale 1ns / 1ps
`include "btree_table_search_unit_defines.svh"

module bts_datapath #(
  parameter int NODE_COUNT = 128,
  parameter int MAX_KEYS   = 15,
  parameter int KEY_BITS   = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bts_pkg::item_t              item_i,
  input  logic [bts_pkg::NODE_W-1:0]  root_i,
  input  bts_pkg::cmd_t               cmd_i,
  output bts_pkg::status_t            status_o,
  output bts_pkg::res_t               res_o
);

  localparam int NW     = $clog2(NODE_COUNT);
  localparam int VW     = $clog2(NODE_COUNT + 1);
  localparam int XW     = $clog2(MAX_KEYS + 1);
  localparam int KDEPTH = NODE_COUNT * MAX_KEYS;
  localparam int CDEPTH = NODE_COUNT * (MAX_KEYS + 1);
  localparam int KAW    = $clog2(KDEPTH);
  localparam int CAW    = $clog2(CDEPTH);

  logic [bts_pkg::CNT_W-1:0]  cnt_mem   [NODE_COUNT];
  logic [KEY_BITS-1:0]        key_mem   [KDEPTH];
  logic [bts_pkg::NODE_W-1:0] child_mem [CDEPTH];

  logic [NW-1:0]              clr_idx_q;
  logic [bts_pkg::NODE_W-1:0] cur_q;
  logic [VW-1:0]              visits_q;
  logic [XW-1:0]              kidx_q, kidx_d;
  logic [KAW-1:0]             kbase_q;
  logic [CAW-1:0]             cbase_q;
  logic signed [KEY_BITS-1:0] target_q;
  logic [bts_pkg::CNT_W-1:0]  cnt_rd_q;
  logic signed [KEY_BITS-1:0] key_rd_q;
  logic [bts_pkg::NODE_W-1:0] child_rd_q;
  bts_pkg::res_t              pend_q;
  bts_pkg::res_t              res_q;

  logic signed [KEY_BITS-1:0] wkey, skey;
  logic                       node_in_tab, slot_le_max;
  logic                       wr_cnt, wr_key, wr_child, key_re;
  logic [NW-1:0]              cnt_waddr;
  logic [bts_pkg::CNT_W-1:0]  cnt_wdata;
  logic [KAW-1:0]             key_waddr, key_raddr;
  logic [CAW-1:0]             child_waddr, child_raddr;

  // Keys: sign-extend the 32-bit field, then wrap to the stored width.
  assign wkey = KEY_BITS'($signed(item_i.key_value));
  assign skey = KEY_BITS'($signed(item_i.search_key));

  assign node_in_tab = 32'(item_i.node_index) < NODE_COUNT;
  assign slot_le_max = 32'(item_i.slot) <= MAX_KEYS;

  assign wr_cnt   = cmd_i.wr_item && (item_i.op == bts_pkg::OP_SET_COUNT) && node_in_tab;
  assign wr_key   = cmd_i.wr_item && (item_i.op == bts_pkg::OP_WRITE_KEY) && node_in_tab &&
                    (item_i.slot != '0) && slot_le_max;
  assign wr_child = cmd_i.wr_item && (item_i.op == bts_pkg::OP_WRITE_CHILD) && node_in_tab &&
                    slot_le_max;

  assign cnt_waddr   = cmd_i.clr ? clr_idx_q : NW'(item_i.node_index);
  assign cnt_wdata   = cmd_i.clr ? '0 :
                       (32'(item_i.key_count) > MAX_KEYS) ? bts_pkg::CNT_W'(MAX_KEYS) :
                       item_i.key_count;
  assign key_waddr   = KAW'(32'(item_i.node_index) * MAX_KEYS + 32'(item_i.slot) - 32'd1);
  assign child_waddr = CAW'(32'(item_i.node_index) * (MAX_KEYS + 1) + 32'(item_i.slot));

  always_comb begin
    kidx_d = kidx_q;
    if (cmd_i.node_rd) begin
      kidx_d = '0;
    end else if (cmd_i.key_next) begin
      kidx_d = XW'(32'(kidx_q) + 32'd1);
    end
  end

  // Skip the read past the node's last key; that slot is never compared.
  assign key_re      = cmd_i.key_rd ||
                       (cmd_i.key_next && (32'(kidx_q) + 32'd1 < 32'(cnt_rd_q)));
  assign key_raddr   = kbase_q + KAW'(kidx_d);
  assign child_raddr = cbase_q + CAW'(kidx_q);

  always_ff @(posedge clk_i) begin
    if (wr_cnt || cmd_i.clr) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd_i.node_rd) begin
      cnt_rd_q <= cnt_mem[NW'(cur_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_mem[key_waddr] <= wkey;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_child) begin
      child_mem[child_waddr] <= item_i.child_index;
    end
    if (cmd_i.child_rd) begin
      child_rd_q <= child_mem[child_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      cur_q     <= '0;
      visits_q  <= '0;
      kidx_q    <= '0;
    end else begin
      kidx_q <= kidx_d;
      if (cmd_i.clr) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
      if (cmd_i.start) begin
        cur_q    <= root_i;
        visits_q <= '0;
      end else if (cmd_i.descend) begin
        cur_q <= child_rd_q;
      end
      if (cmd_i.node_rd) begin
        visits_q <= visits_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      target_q <= skey;
    end
    if (cmd_i.node_rd) begin
      kbase_q <= KAW'(32'(cur_q) * MAX_KEYS);
      cbase_q <= CAW'(32'(cur_q) * (MAX_KEYS + 1));
    end
    if (cmd_i.res_miss) begin
      pend_q <= '0;
    end else if (cmd_i.res_dx) begin
      pend_q                <= '0;
      pend_q.depth_exceeded <= 1'b1;
    end else if (cmd_i.res_found) begin
      pend_q.found          <= 1'b1;
      pend_q.found_node     <= cur_q;
      pend_q.found_slot     <= bts_pkg::SLOT_W'(32'(kidx_q) + 32'd1);
      pend_q.depth_exceeded <= 1'b0;
    end
    if (cmd_i.out_load) begin
      res_q <= pend_q;
    end
  end

  assign status_o.clr_done     = (clr_idx_q == NW'(NODE_COUNT - 1));
  assign status_o.in_search    = (item_i.op == bts_pkg::OP_SEARCH);
  assign status_o.node_ok      = (cur_q != '0) && (32'(cur_q) < NODE_COUNT);
  assign status_o.depth_hit    = 32'(visits_q) >= NODE_COUNT;
  assign status_o.key_in_range = 32'(kidx_q) < 32'(cnt_rd_q);
  assign status_o.key_ge       = key_rd_q >= target_q;
  assign status_o.key_eq       = key_rd_q == target_q;

  assign res_o = res_q;

  `BTS_ASSERT_IMP(a_visit_bound, cmd_i.node_rd, 32'(visits_q) < NODE_COUNT, "node entered past the visit limit")

endmodule

FILE: hw/rtl/btree_table_search_unit.sv
// Top level of the B-tree search unit: channels, APB register and submodules.
`timescale 1ns / 1ps
`include "btree_table_search_unit_defines.svh"
// Write items (set count, write key, write child) are taken one per cycle while no search is in flight.
// A search scans the keys of each visited node one key per cycle
// through the key memory read port.
// One search is in flight at a time; a finished result waits in the output register.
// After reset the node count table is cleared, one entry a cycle, with no input transfer
// accepted until the clear is done. APB writes are taken throughout.

module btree_table_search_unit #(
  parameter int NODE_COUNT = 128,
  parameter int MAX_KEYS   = 15,
  parameter int KEY_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bts_in_if.sink      in_ch_i,
  bts_out_if.source   out_ch_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register map: the root node register sits at byte address 0.
  localparam logic REG_ROOT = 1'b0;

  logic [bts_pkg::NODE_W-1:0] root_q;
  logic                       cfg_wr;
  bts_pkg::item_t             item;
  bts_pkg::cmd_t              cmd;
  bts_pkg::status_t           status;
  bts_pkg::res_t              res;
  logic                       in_ready, out_valid;

  // APB: zero-wait, write lands on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ROOT) ? 32'(root_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_wr && (paddr[2] == REG_ROOT)) begin
      root_q <= pwdata[bts_pkg::NODE_W-1:0];
    end
  end

  // Input transfer payload as one struct.
  assign item.op          = bts_pkg::op_e'(in_ch_i.op);
  assign item.node_index  = in_ch_i.node_index;
  assign item.slot        = in_ch_i.slot;
  assign item.key_count   = in_ch_i.key_count;
  assign item.key_value   = in_ch_i.key_value;
  assign item.child_index = in_ch_i.child_index;
  assign item.search_key  = in_ch_i.search_key;

  assign in_ch_i.ready = in_ready;

  bts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bts_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .MAX_KEYS   (MAX_KEYS),
    .KEY_BITS   (KEY_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .root_i   (root_q),
    .cmd_i    (cmd),
    .status_o (status),
    .res_o    (res)
  );

  // Result transfer: output register drives the channel directly.
  assign out_ch_o.valid          = out_valid;
  assign out_ch_o.found          = res.found;
  assign out_ch_o.found_node     = res.found_node;
  assign out_ch_o.found_slot     = res.found_slot;
  assign out_ch_o.depth_exceeded = res.depth_exceeded;

  `BTS_ASSERT_IMP(a_found_fields, out_valid && res.found, (res.found_node != '0) && (res.found_slot != '0) && !res.depth_exceeded, "found result with empty location")

endmodule
